// File: rtl/ssdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdm_pkg
// shared types and constants of the stereo sigma-delta pwm modulator
// ----------------------------------------------------------------------------
package ssdm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VOLUME_W = 7;
    localparam int DUTY_W   = 10;
    localparam int INTEG_W  = 32;
    localparam int PROD_W   = VOLUME_W + 1 + SAMPLE_W;
    localparam int DRIVE_W  = DUTY_W + SAMPLE_W;
    localparam int GAIN_SHIFT = 6;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [VOLUME_W-1:0] VOLUME_RESET     = 7'd64;
    localparam logic [DUTY_W-1:0]   FULL_SCALE_RESET = 10'd218;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_VOLUME     = 1'b0,
        REG_FULL_SCALE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_UPDATE
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic scale;
        logic update;
    } lane_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/ssdm_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdm interfaces
// valid/ready channels for sample pairs and duty pairs
// ----------------------------------------------------------------------------
interface ssdm_sample_if import ssdm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface ssdm_duty_if import ssdm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;

    modport source (output valid, output left_duty, output right_duty, input ready);
    modport sink   (input valid, input left_duty, input right_duty, output ready);
endinterface
`default_nettype wire

// File: rtl/ssdm_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdm_lane
// one channel: gain, offset, full-scale multiply and second-order loop
// ----------------------------------------------------------------------------
module ssdm_lane import ssdm_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic [VOLUME_W-1:0]        volume,
    input  wire logic [DUTY_W-1:0]          full_scale,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic [DUTY_W-1:0]               duty
);

    localparam int ALIGN = SAMPLE_W - FRACTION_BITS;

    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [INTEG_W-1:0]        drive_reg, drive_next;
    logic [INTEG_W-1:0]        first_reg, first_next;
    logic [INTEG_W-1:0]        second_reg, second_next;

    logic signed [PROD_W-1:0]  bias;
    logic signed [PROD_W-1:0]  quot;
    logic [SAMPLE_W-1:0]       sat;
    logic [SAMPLE_W-1:0]       off;
    logic [DRIVE_W-1:0]        drive_prod;
    logic signed [INTEG_W-1:0] upper;
    logic [INTEG_W-1:0]        fb;

    // gain numerator times sample
    assign prod_next = $signed({1'b0, volume}) * sample;

    // divide by 64 rounding toward zero, saturate, offset to unsigned, scale by full scale and align
    always_comb
    begin
        bias = prod_reg[PROD_W-1] ? PROD_W'(63) : '0;
        quot = (prod_reg + bias) >>> GAIN_SHIFT;
        if (quot > PROD_W'(32767))
        begin
            sat = 16'h7fff;
        end
        else if (quot < -PROD_W'(32768))
        begin
            sat = 16'h8000;
        end
        else
        begin
            sat = quot[SAMPLE_W-1:0];
        end
        off        = {~sat[SAMPLE_W-1], sat[SAMPLE_W-2:0]};
        drive_prod = DRIVE_W'(full_scale) * DRIVE_W'(off);
        drive_next = INTEG_W'(drive_prod >> ALIGN);
    end

    // duty from the upper integrator, then loop update
    always_comb
    begin
        upper = $signed(second_reg) >>> FRACTION_BITS;
        if (second_reg[INTEG_W-1])
        begin
            duty = '0;
        end
        else if (upper > $signed({{(INTEG_W-DUTY_W){1'b0}}, full_scale}))
        begin
            duty = full_scale;
        end
        else
        begin
            duty = upper[DUTY_W-1:0];
        end
        fb          = INTEG_W'(duty) << FRACTION_BITS;
        first_next  = first_reg + drive_reg - fb;
        second_next = second_reg + first_next - fb;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.scale)
        begin
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (ctrl.update)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ssdm_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdm_merge
// joins the two lane duties into one output item register
// ----------------------------------------------------------------------------
module ssdm_merge import ssdm_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [DUTY_W-1:0] left_duty,
    input  wire logic [DUTY_W-1:0] right_duty,
    output logic                   free,
    ssdm_duty_if.source            duties
);

    logic              valid_reg, valid_next;
    logic [DUTY_W-1:0] left_reg;
    logic [DUTY_W-1:0] right_reg;

    assign free = !valid_reg || duties.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (duties.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= left_duty;
            right_reg <= right_duty;
        end
    end

    assign duties.valid      = valid_reg;
    assign duties.left_duty  = left_reg;
    assign duties.right_duty = right_reg;

endmodule
`default_nettype wire

// File: rtl/stereo_sigma_delta_pwm_modulator.sv
`default_nettype none
// an accepted sample item passes the idle, scale and update states before its duty
//   item is valid; the update step waits while the output register holds an untaken item
// one sample item at a time: the three-step sequencer takes no new item until the
//   last one is through (gain multiply, full-scale multiply, integrator update)
// reset: volume 64, full scale 218, all four integrators zero, no item held
// ----------------------------------------------------------------------------
// stereo_sigma_delta_pwm_modulator
// stereo pcm to pwm duty converter with a second-order sigma-delta loop per
// channel; two identical lanes run side by side and a merge stage pairs them
// ----------------------------------------------------------------------------
module stereo_sigma_delta_pwm_modulator import ssdm_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ssdm_sample_if.sink            samples,
    ssdm_duty_if.source            duties,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [VOLUME_W-1:0] volume_reg;
    logic [DUTY_W-1:0]   full_scale_reg;
    logic                cfg_write;
    reg_index_t          cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    // registers sit at byte addresses 0 and 4; the low address bits are ignored
    assign cfg_sel   = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg     <= VOLUME_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_VOLUME:
                begin
                    volume_reg <= pwdata[VOLUME_W-1:0];
                end
                REG_FULL_SCALE:
                begin
                    full_scale_reg <= pwdata[DUTY_W-1:0];
                end
                default:
                begin
                    volume_reg <= volume_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_VOLUME:     prdata = DATA_W'(volume_reg);
            REG_FULL_SCALE: prdata = DATA_W'(full_scale_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: one item at a time through both lanes
    //   idle   - take a sample pair, lanes form volume * sample
    //   scale  - lanes form the offset sample times full scale
    //   update - wait for a free output slot, then step both loops and
    //            hand the duty pair to the merge stage
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;
    lane_ctrl_t ctrl;
    logic       accept;
    logic       out_free;

    assign accept = samples.valid && samples.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        samples.ready = 1'b0;
        ctrl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                ctrl.load     = samples.valid;
            end
            ST_SCALE:
            begin
                ctrl.scale = 1'b1;
            end
            ST_UPDATE:
            begin
                ctrl.update = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // lanes: left and right channels, identical datapaths
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;

    ssdm_lane #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_left_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .volume     (volume_reg),
        .full_scale (full_scale_reg),
        .sample     (samples.left_sample),
        .duty       (left_duty)
    );

    ssdm_lane #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_right_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .volume     (volume_reg),
        .full_scale (full_scale_reg),
        .sample     (samples.right_sample),
        .duty       (right_duty)
    );

    // ------------------------------------------------------------------
    // merge stage: output item register, lets the next pair in while
    // the previous duty pair waits to be taken
    // ------------------------------------------------------------------
    ssdm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ctrl.update),
        .left_duty  (left_duty),
        .right_duty (right_duty),
        .free       (out_free),
        .duties     (duties)
    );

`ifndef ASSERT_OFF
    // the loops only step when their result has somewhere to go
    a_update_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |-> out_free)
        else $error("integrator update with output slot occupied");

    // an accepted pair passes through the scale step into the update step
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 (state_reg == ST_UPDATE))
        else $error("accepted item did not reach update step");

    // every loop step produces a pending duty item
    a_update_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |=> duties.valid)
        else $error("loop step without an output item");
`endif

endmodule
`default_nettype wire

// File: tb/stereo_sigma_delta_pwm_modulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_sigma_delta_pwm_modulator_tb
// drives stereo sample items through the modulator and checks every duty item
// against an in-bench second-order loop; a directed table covers the corners
// (saturating gain, zero gain, zero and maximum full scale, integrator wrap),
// then random phases run under changing register settings with random stalls
// on both channels
// ----------------------------------------------------------------------------
module stereo_sigma_delta_pwm_modulator_tb;
    import ssdm_pkg::*;

    localparam int FRACTION_BITS = 16;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_REPORTS   = 10;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
    } duty_pair_t;

    // directed rows: a sample pair, or a register write whose value sits in left_in
    typedef enum logic [1:0] {
        ROW_PAIR,
        ROW_VOLUME,
        ROW_FULL_SCALE
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        left_in;
        int        right_in;
        bit        known;
        int        want_left;
        int        want_right;
    } directed_row_t;

    typedef enum logic [2:0] {
        STIM_UNIFORM,
        STIM_HELD,
        STIM_SMALL,
        STIM_EXTREME,
        STIM_FLOOR
    } stim_style_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ssdm_sample_if sample_ch ();
    ssdm_duty_if   duty_ch ();

    stereo_sigma_delta_pwm_modulator #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .duties  (duty_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // loop predictor: own copy of the registers and the four integrators
    // ------------------------------------------------------------------
    logic [VOLUME_W-1:0] gain_setting   = VOLUME_RESET;
    logic [DUTY_W-1:0]   period_setting = FULL_SCALE_RESET;
    logic [INTEG_W-1:0]  left_acc1      = '0;
    logic [INTEG_W-1:0]  left_acc2      = '0;
    logic [INTEG_W-1:0]  right_acc1     = '0;
    logic [INTEG_W-1:0]  right_acc2     = '0;

    duty_pair_t duty_expect_q [$];

    bit idling_on;
    int mismatch_count = 0;
    int duty_count     = 0;
    int quiet_cycles   = 0;
    int sink_hold      = 0;
    int sink_draw;

    int unsigned gain_corners [5]   = '{64, 127, 0, 65, 1};
    int unsigned period_corners [5] = '{1023, 1, 1023, 0, 218};
    int          corner_samples [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    directed_row_t directed_plan [27] = '{
        // first item after reset: second integrator is zero, so both duties are zero
        '{ROW_PAIR,        0,      0, 1'b1, 0, 0},
        '{ROW_PAIR,    32767, -32768, 1'b0, 0, 0},
        '{ROW_PAIR,   -32768,  32767, 1'b0, 0, 0},
        '{ROW_PAIR,       -1,      1, 1'b0, 0, 0},
        '{ROW_PAIR,    21845, -21846, 1'b0, 0, 0},
        // gain above unity: scaled sample saturates
        '{ROW_VOLUME,    127,      0, 1'b0, 0, 0},
        '{ROW_PAIR,    32767, -32768, 1'b0, 0, 0},
        '{ROW_PAIR,   -32768,  32767, 1'b0, 0, 0},
        '{ROW_PAIR,    20000, -20000, 1'b0, 0, 0},
        // smallest gain: division truncates toward zero for both signs
        '{ROW_VOLUME,      1,      0, 1'b0, 0, 0},
        '{ROW_PAIR,      -63,     63, 1'b0, 0, 0},
        '{ROW_PAIR,      -65,     65, 1'b0, 0, 0},
        '{ROW_VOLUME,      0,      0, 1'b0, 0, 0},
        '{ROW_PAIR,    12345, -12345, 1'b0, 0, 0},
        // zero full scale clamps every duty to zero
        '{ROW_FULL_SCALE,  0,      0, 1'b0, 0, 0},
        '{ROW_PAIR,    32767, -32768, 1'b1, 0, 0},
        '{ROW_PAIR,   -32768,  32767, 1'b1, 0, 0},
        '{ROW_VOLUME,     64,      0, 1'b0, 0, 0},
        '{ROW_FULL_SCALE, 1023,    0, 1'b0, 0, 0},
        '{ROW_PAIR,    32767,  32767, 1'b0, 0, 0},
        '{ROW_PAIR,    32767,  32767, 1'b0, 0, 0},
        '{ROW_PAIR,   -32768, -32768, 1'b0, 0, 0},
        '{ROW_PAIR,   -32768, -32768, 1'b0, 0, 0},
        '{ROW_FULL_SCALE,  1,      0, 1'b0, 0, 0},
        '{ROW_PAIR,    32767, -32768, 1'b0, 0, 0},
        '{ROW_PAIR,   -32768,  32767, 1'b0, 0, 0},
        '{ROW_PAIR,        0,      0, 1'b0, 0, 0}
    };

    // gain by volume/64 with truncation toward zero, saturate, offset to
    // unsigned, scale by the full-scale count and align to the fraction
    function automatic logic [INTEG_W-1:0] scaled_drive(input logic signed [SAMPLE_W-1:0] sample);
        int                 gained;
        logic [INTEG_W-1:0] offset;
        gained = int'(gain_setting) * int'(sample) / (1 << GAIN_SHIFT);
        if (gained > 32767)
            gained = 32767;
        if (gained < -32768)
            gained = -32768;
        offset = INTEG_W'(gained + 32768);
        return (INTEG_W'(period_setting) * offset) >> (SAMPLE_W - FRACTION_BITS);
    endfunction

    // duty is taken from the upper integrator before either integrator moves
    task automatic sigma_delta_step(inout logic [INTEG_W-1:0] acc1,
                                    inout logic [INTEG_W-1:0] acc2,
                                    input logic [INTEG_W-1:0] drive,
                                    output logic [DUTY_W-1:0] duty);
        logic signed [INTEG_W-1:0] level;
        logic [INTEG_W-1:0]        feedback;
        level = $signed(acc2) >>> FRACTION_BITS;
        if (level < 0)
            duty = '0;
        else if (level > $signed(INTEG_W'(period_setting)))
            duty = period_setting;
        else
            duty = level[DUTY_W-1:0];
        feedback = INTEG_W'(duty) << FRACTION_BITS;
        acc1 = acc1 + drive - feedback;
        acc2 = acc2 + acc1 - feedback;
    endtask

    // mostly back to back, some short gaps, the odd long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(input stim_style_t style,
                                                               input logic signed [SAMPLE_W-1:0] held,
                                                               input int item);
        case (style)
            STIM_HELD:    return held;
            STIM_SMALL:   return SAMPLE_W'(int'($urandom_range(0, 256)) - 128);
            STIM_EXTREME: return SAMPLE_W'(corner_samples[$urandom_range(0, 6)]);
            // push the loop to the top, then starve it so the integrators wrap
            STIM_FLOOR:   return (item < 20) ? 16'sh7FFF : 16'sh8000;
            default:      return SAMPLE_W'($urandom);
        endcase
    endfunction

    // offer one sample item; on acceptance predict its duty item
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] left_in,
                             input logic signed [SAMPLE_W-1:0] right_in,
                             input bit known,
                             input duty_pair_t typed);
        int         gap;
        duty_pair_t predicted;
        gap = idling_on ? gap_length() : 0;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.left_sample  <= left_in;
        sample_ch.right_sample <= right_in;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sigma_delta_step(left_acc1, left_acc2, scaled_drive(left_in), predicted.left_duty);
        sigma_delta_step(right_acc1, right_acc2, scaled_drive(right_in), predicted.right_duty);
        duty_expect_q.push_back(known ? typed : predicted);
    endtask

    // stop offering items and wait until every duty item has come out
    task automatic drain_duties();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (duty_expect_q.size() != 0);
    endtask

    // setup then access cycle; upper bits carry junk that the block must drop
    task automatic write_register(input reg_index_t index, input int unsigned value);
        logic [DATA_W-1:0] word;
        word = DATA_W'($urandom);
        if (index == REG_VOLUME)
            word[VOLUME_W-1:0] = value[VOLUME_W-1:0];
        else
            word[DUTY_W-1:0] = value[DUTY_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_VOLUME)
            gain_setting = word[VOLUME_W-1:0];
        else
            period_setting = word[DUTY_W-1:0];
        // leave the bus idle before the next transfer
        @(posedge clk);
    endtask

    task automatic count_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // duty sink: random stalls, with whole phases running without them
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (sink_hold != 0)
        begin
            duty_ch.ready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end
        else
        begin
            sink_draw     = idling_on ? gap_length() : 0;
            duty_ch.ready <= (sink_draw == 0);
            sink_hold     <= (sink_draw == 0) ? 0 : sink_draw - 1;
        end
    end

    // duty checker: each accepted duty item against the oldest prediction
    always @(posedge clk)
    begin
        duty_pair_t want;
        if (rst_n && duty_ch.valid && duty_ch.ready)
        begin
            if (duty_expect_q.size() == 0)
                count_mismatch($sformatf("duty item %0d not expected: left %0d right %0d",
                                         duty_count, duty_ch.left_duty, duty_ch.right_duty));
            else
            begin
                want = duty_expect_q.pop_front();
                if (duty_ch.left_duty !== want.left_duty ||
                    duty_ch.right_duty !== want.right_duty)
                    count_mismatch($sformatf(
                        "duty item %0d: left exp %0d got %0d, right exp %0d got %0d",
                        duty_count, want.left_duty, duty_ch.left_duty,
                        want.right_duty, duty_ch.right_duty));
            end
            duty_count++;
        end
    end

    // watchdog: too long without any item moving on either channel
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (duty_ch.valid && duty_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        duty_pair_t                 typed;
        stim_style_t                style;
        int unsigned                phase_gain;
        int unsigned                phase_period;
        logic signed [SAMPLE_W-1:0] held_left;
        logic signed [SAMPLE_W-1:0] held_right;

        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.left_sample  = '0;
        sample_ch.right_sample = '0;
        duty_ch.ready          = 1'b0;
        idling_on              = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; register rows wait for the block to go idle
        foreach (directed_plan[i])
        begin
            case (directed_plan[i].kind)
                ROW_VOLUME:
                begin
                    drain_duties();
                    write_register(REG_VOLUME, directed_plan[i].left_in);
                end
                ROW_FULL_SCALE:
                begin
                    drain_duties();
                    write_register(REG_FULL_SCALE, directed_plan[i].left_in);
                end
                default:
                begin
                    typed.left_duty  = DUTY_W'(directed_plan[i].want_left);
                    typed.right_duty = DUTY_W'(directed_plan[i].want_right);
                    send_pair(SAMPLE_W'(directed_plan[i].left_in),
                              SAMPLE_W'(directed_plan[i].right_in),
                              directed_plan[i].known, typed);
                end
            endcase
        end

        // random phases: corner settings first, then random ones
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 5)
            begin
                phase_gain   = gain_corners[phase];
                phase_period = period_corners[phase];
            end
            else
            begin
                phase_gain   = $urandom_range(0, 127);
                phase_period = $urandom_range(0, 1023);
            end
            drain_duties();
            write_register(REG_VOLUME, phase_gain);
            write_register(REG_FULL_SCALE, phase_period);

            // one phase always runs flat out on both channels
            idling_on = (phase != 2) && ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 7))
                4:       style = STIM_HELD;
                5:       style = STIM_SMALL;
                6:       style = STIM_EXTREME;
                7:       style = STIM_FLOOR;
                default: style = STIM_UNIFORM;
            endcase
            // first phase runs at full scale and unity gain: wrap the integrators
            if (phase == 0)
                style = STIM_FLOOR;

            held_left  = SAMPLE_W'($urandom);
            held_right = SAMPLE_W'($urandom);
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    held_left  = SAMPLE_W'($urandom);
                    held_right = SAMPLE_W'($urandom);
                end
                send_pair(draw_sample(style, held_left, item),
                          draw_sample(style, held_right, item), 1'b0, '0);
            end
        end

        drain_duties();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && duty_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
